### src/arp_pkg.sv
`timescale 1ns / 1ps

package arp_pkg;

  localparam int CACHE_ENTRIES_DEF = 32;

  localparam logic [10:0] MSG_MIN_LEN = 11'd28;
  localparam logic [15:0] HW_ETHER    = 16'h0001;
  localparam logic [7:0]  HW_ADDR_LEN = 8'd6;
  localparam logic [15:0] PROTO_IP    = 16'h0800;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;

  localparam logic ACT_MESSAGE = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_REPLY     = 3'd1;
  localparam logic [2:0] STAT_SHORT     = 3'd2;
  localparam logic [2:0] STAT_BAD_HW    = 3'd3;
  localparam logic [2:0] STAT_BAD_PROTO = 3'd4;
  localparam logic [2:0] STAT_HIT       = 3'd5;
  localparam logic [2:0] STAT_MISS      = 3'd6;

  localparam logic REG_LOCAL_IP  = 1'b0;
  localparam logic REG_IFACE_EN  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [10:0] frame_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] reply_target_mac;
    logic [31:0] reply_target_ip;
    logic [47:0] found_mac;
  } out_word_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

endpackage

### src/arp_mem.sv
`timescale 1ns / 1ps

module arp_mem import arp_pkg::*; #(
  parameter int DEPTH = CACHE_ENTRIES_DEF,
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/arp_scan.sv
`timescale 1ns / 1ps

// Compare unit fed one cache entry per cycle: first IP match, oldest stamp.
module arp_scan import arp_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             clear,
  input  logic             ent_vld,
  input  logic [IDX_W-1:0] ent_idx,
  input  entry_t           ent,
  input  logic [31:0]      key_ip,
  output logic             found,
  output logic [IDX_W-1:0] found_idx,
  output logic [47:0]      found_mac,
  output logic [IDX_W-1:0] oldest_idx
);

  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic [47:0]      found_mac_r;
  logic             min_vld_r;
  logic [IDX_W-1:0] min_idx_r;
  logic [31:0]      min_stamp_r;

  logic hit;
  logic older;

  assign hit   = ent_vld && !found_r && (ent.ip == key_ip);
  // strictly older only, so ties keep the lower index
  assign older = ent_vld && (!min_vld_r || (ent.stamp < min_stamp_r));

  always_ff @(posedge clk) begin
    if (clear) begin
      found_r   <= 1'b0;
      min_vld_r <= 1'b0;
    end else begin
      if (hit) begin
        found_r     <= 1'b1;
        found_idx_r <= ent_idx;
        found_mac_r <= ent.mac;
      end
      if (older) begin
        min_vld_r   <= 1'b1;
        min_idx_r   <= ent_idx;
        min_stamp_r <= ent.stamp;
      end
    end
  end

  assign found      = found_r;
  assign found_idx  = found_idx_r;
  assign found_mac  = found_mac_r;
  assign oldest_idx = min_idx_r;

endmodule

### src/arp_cache_engine.sv
`timescale 1ns / 1ps

// ARP offload engine with an IP-to-MAC cache. A word is taken on a clock edge with
// start high and busy low; each word yields exactly one result word, shown on
// out_word for one cycle with out_valid high. The receiver cannot stall, so it must
// take the result in that cycle. A message failing the length, hardware or protocol
// check skips the cache walk. Otherwise the cache is walked one entry per cycle
// through a single read port and one compare unit, over the filled entries only,
// stopping early at the first IP match, and out_valid is high in the first cycle
// with busy low. A refresh or insert is one write at the end of the walk.
// Entries are filled in index order and never freed, so a fill count stands in
// for per-entry valid bits and no clearing pass is needed after reset.
// Configuration may be written at any time (cfg_ready is always high) but is
// meant to change only while the engine is idle.
module arp_cache_engine import arp_pkg::*; #(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  in_word_t   word_r, word_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;

  logic [31:0]      local_ip_r;
  logic             iface_en_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [31:0]      stamp_ctr_r, stamp_ctr_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;

  // memory and compare unit hookup
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             scan_clear;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic [47:0]      found_mac;
  logic [IDX_W-1:0] oldest_idx;

  // message checks, in priority order
  logic is_short, bad_hw, bad_proto, msg_bad, for_us, accept;
  assign is_short  = word_r.frame_length < MSG_MIN_LEN;
  assign bad_hw    = (word_r.hw_type != HW_ETHER) || (word_r.hw_len != HW_ADDR_LEN);
  assign bad_proto = (word_r.proto_type != PROTO_IP) || (word_r.proto_len != PROTO_ADDR_LEN);
  assign for_us    = iface_en_r && (local_ip_r == word_r.target_ip);

  // same checks on the incoming word, to skip the walk
  assign msg_bad = (in_word.action == ACT_MESSAGE) &&
                   ((in_word.frame_length < MSG_MIN_LEN) ||
                    (in_word.hw_type != HW_ETHER) || (in_word.hw_len != HW_ADDR_LEN) ||
                    (in_word.proto_type != PROTO_IP) ||
                    (in_word.proto_len != PROTO_ADDR_LEN));

  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign scan_clear = accept;

  // walk: issue reads over the filled entries until a match comes back
  assign rd_en   = (state_r == S_SCAN) && (iss_r < fill_r) && !found;
  assign rd_addr = iss_r[IDX_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    fill_nxt      = fill_r;
    stamp_ctr_nxt = stamp_ctr_r;
    iss_nxt       = iss_r;
    wr_en         = 1'b0;
    wr_addr       = found_idx;
    wr_data       = '{ip: word_r.sender_ip, mac: word_r.sender_mac, stamp: stamp_ctr_r};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          word_nxt  = in_word;
          iss_nxt   = '0;
          state_nxt = msg_bad ? S_FINISH : S_SCAN;
        end
      end

      S_SCAN: begin
        if (rd_en) begin
          iss_nxt = iss_r + CNT_W'(1);
        end
        // nothing in flight and nothing left to issue
        if (!rd_vld_r && ((iss_r == fill_r) || found)) begin
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = '0;
        state_nxt     = S_IDLE;
        if (word_r.action == ACT_RESOLVE) begin
          out_word_nxt.status    = found ? STAT_HIT : STAT_MISS;
          out_word_nxt.found_mac = found ? found_mac : 48'd0;
        end else if (is_short) begin
          out_word_nxt.status = STAT_SHORT;
        end else if (bad_hw) begin
          out_word_nxt.status = STAT_BAD_HW;
        end else if (bad_proto) begin
          out_word_nxt.status = STAT_BAD_PROTO;
        end else begin
          out_word_nxt.status = STAT_OK;
          if (found) begin
            // refresh MAC and age of the cached sender
            wr_en         = 1'b1;
            wr_addr       = found_idx;
            stamp_ctr_nxt = stamp_ctr_r + 32'd1;
          end else if (for_us) begin
            // insert: next free slot, or the oldest when full
            wr_en         = 1'b1;
            stamp_ctr_nxt = stamp_ctr_r + 32'd1;
            if (fill_r == FULL_CNT) begin
              wr_addr = oldest_idx;
            end else begin
              wr_addr  = fill_r[IDX_W-1:0];
              fill_nxt = fill_r + CNT_W'(1);
            end
          end
          if (for_us && (word_r.opcode == OP_REQUEST)) begin
            out_word_nxt.status           = STAT_REPLY;
            out_word_nxt.reply_target_mac = word_r.sender_mac;
            out_word_nxt.reply_target_ip  = word_r.sender_ip;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      stamp_ctr_r <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      local_ip_r  <= '0;
      iface_en_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      stamp_ctr_r <= stamp_ctr_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_en;
      word_r      <= word_nxt;
      out_word_r  <= out_word_nxt;
      rd_idx_r    <= rd_addr;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LOCAL_IP: local_ip_r <= cfg_data;
          REG_IFACE_EN: iface_en_r <= cfg_data[0];
          default:      ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  arp_mem #(
    .DEPTH (CACHE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  arp_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk        (clk),
    .clear      (scan_clear),
    .ent_vld    (rd_vld_r),
    .ent_idx    (rd_idx_r),
    .ent        (rd_data),
    .key_ip     ((word_r.action == ACT_RESOLVE) ? word_r.query_ip : word_r.sender_ip),
    .found      (found),
    .found_idx  (found_idx),
    .found_mac  (found_mac),
    .oldest_idx (oldest_idx)
  );

endmodule
